FILE: hdl/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
// Used by clt_front, clt_queue, clt_back and command_line_tokenizer_core.
`default_nettype none

package clt_pkg;

  localparam int POOL_BYTES      = 8192;
  localparam int TOKEN_LIMIT_MAX = 512;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int SLOTS           = 4;

  localparam logic [12:0] POOL_LAST = 13'(POOL_BYTES - 2);
  localparam logic [9:0]  LIMIT_CAP = 10'(TOKEN_LIMIT_MAX);

  // Parser modes.
  localparam logic [2:0] MODE_LINE    = 3'd0;
  localparam logic [2:0] MODE_SKIP    = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_QUOTED  = 3'd3;
  localparam logic [2:0] MODE_BARE    = 3'd4;
  localparam logic [2:0] MODE_REST_WS = 3'd5;
  localparam logic [2:0] MODE_REST    = 3'd6;
  localparam logic [2:0] MODE_IGNORE  = 3'd7;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DC4    = 8'h14;
  localparam logic [7:0] CH_NAK    = 8'h15;
  localparam logic [7:0] CH_SYN    = 8'h16;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  typedef struct packed {
    logic        kind;
    logic [12:0] pool_address;
    logic [7:0]  pool_byte;
    logic        token_start;
    logic [8:0]  token_index;
    logic [9:0]  token_count;
  } result_t;

  // All results caused by one input byte; last is the index of the final slot.
  typedef struct packed {
    logic [1:0]            last;
    result_t [SLOTS-1:0]   slot;
  } bundle_t;

endpackage

`default_nettype wire

FILE: hdl/clt_front.sv
// Front end: accepts line bytes, runs the tokenizer state and builds the result
// bundle for each byte. Depends on clt_pkg.
`default_nettype none

module clt_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       char_in,
  input  wire logic [9:0]       token_limit,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire logic             q_full,
  output logic                  q_push,
  output clt_pkg::bundle_t      q_data
);

  typedef struct packed {
    logic [2:0]                           mode;
    logic                                 held;
    logic                                 star;
    logic                                 sp;
    logic [9:0]                           tok;
    logic [9:0]                           lim;
    logic [12:0]                          base;
    logic [2:0]                           ne;
    logic [2:0]                           n;
    clt_pkg::result_t [clt_pkg::SLOTS-1:0] slot;
  } work_t;

  logic [2:0]  mode;
  logic        held;
  logic        star;
  logic        sp;
  logic [9:0]  tok;
  logic [9:0]  lim;
  logic [12:0] pos;
  logic [12:0] pos_next;
  logic [13:0] pos_sum;
  logic        accept;
  work_t       w;

  function automatic logic is_space(logic [7:0] c);
    return (c != clt_pkg::CH_NUL) && (c <= clt_pkg::CH_SPACE) &&
           (c != clt_pkg::CH_DC4) && (c != clt_pkg::CH_NAK) && (c != clt_pkg::CH_SYN);
  endfunction

  function automatic work_t put(work_t wi, clt_pkg::result_t r);
    work_t wo;
    wo = wi;
    if (wo.n < 3'(clt_pkg::SLOTS)) begin
      wo.slot[wo.n[1:0]] = r;
      wo.n = wo.n + 3'd1;
    end
    return wo;
  endfunction

  function automatic work_t emit(work_t wi, logic [7:0] b);
    work_t            wo;
    logic [13:0]      sum;
    clt_pkg::result_t r;
    wo  = wi;
    sum = {1'b0, wo.base} + {11'd0, wo.ne};
    r.kind         = clt_pkg::KIND_WRITE;
    r.pool_address = (sum >= {1'b0, clt_pkg::POOL_LAST}) ? clt_pkg::POOL_LAST : sum[12:0];
    r.pool_byte    = b;
    r.token_start  = wo.sp;
    r.token_index  = (wo.tok != 10'd0) ? (wo.tok[8:0] - 9'd1) : 9'd0;
    r.token_count  = 10'd0;
    wo    = put(wo, r);
    wo.sp = 1'b0;
    wo.ne = wo.ne + 3'd1;
    return wo;
  endfunction

  function automatic work_t start_token(work_t wi);
    work_t wo;
    wo     = wi;
    wo.tok = wo.tok + 10'd1;
    wo.sp  = 1'b1;
    return wo;
  endfunction

  // Between tokens: stop once the limit is met, or open the final raw token.
  function automatic work_t enter_skip(work_t wi);
    work_t wo;
    wo      = wi;
    wo.mode = clt_pkg::MODE_SKIP;
    if (wo.tok >= wo.lim) begin
      wo.mode = clt_pkg::MODE_IGNORE;
    end else if (wo.tok == wo.lim - 10'd1) begin
      wo      = start_token(wo);
      wo.mode = clt_pkg::MODE_REST_WS;
    end
    return wo;
  endfunction

  // One byte with no slash pending.
  function automatic work_t plain(work_t wi, logic [7:0] c);
    work_t            wo;
    clt_pkg::result_t r;
    wo = wi;
    r  = '0;
    if (c == clt_pkg::CH_NUL) begin
      if (wo.mode == clt_pkg::MODE_BARE || wo.mode == clt_pkg::MODE_QUOTED ||
          wo.mode == clt_pkg::MODE_REST_WS || wo.mode == clt_pkg::MODE_REST) begin
        wo = emit(wo, clt_pkg::CH_NUL);
      end
      r.kind        = clt_pkg::KIND_SUMMARY;
      r.token_count = wo.tok;
      wo      = put(wo, r);
      wo.mode = clt_pkg::MODE_LINE;
      wo.star = 1'b0;
      wo.sp   = 1'b0;
    end else begin
      unique case (wo.mode)
        clt_pkg::MODE_SKIP: begin
          if (is_space(c)) begin
            wo.mode = clt_pkg::MODE_SKIP;
          end else if (c == clt_pkg::CH_SLASH) begin
            wo.held = 1'b1;
          end else if (c == clt_pkg::CH_QUOTE) begin
            wo      = start_token(wo);
            wo.mode = clt_pkg::MODE_QUOTED;
          end else begin
            wo      = start_token(wo);
            wo      = emit(wo, c);
            wo.mode = clt_pkg::MODE_BARE;
          end
        end
        clt_pkg::MODE_COMMENT: begin
          if (c == clt_pkg::CH_SLASH && wo.star) begin
            wo.star = 1'b0;
            wo      = enter_skip(wo);
          end else begin
            wo.star = (c == clt_pkg::CH_STAR);
          end
        end
        clt_pkg::MODE_QUOTED: begin
          if (c == clt_pkg::CH_QUOTE) begin
            wo = emit(wo, clt_pkg::CH_NUL);
            wo = enter_skip(wo);
          end else begin
            wo = emit(wo, c);
          end
        end
        clt_pkg::MODE_BARE: begin
          if (is_space(c)) begin
            wo = emit(wo, clt_pkg::CH_NUL);
            wo = enter_skip(wo);
          end else if (c == clt_pkg::CH_QUOTE) begin
            // The quote ends this token and then opens the next one.
            wo = emit(wo, clt_pkg::CH_NUL);
            wo = enter_skip(wo);
            if (wo.mode == clt_pkg::MODE_SKIP) begin
              wo      = start_token(wo);
              wo.mode = clt_pkg::MODE_QUOTED;
            end else if (wo.mode == clt_pkg::MODE_REST_WS) begin
              wo.mode = clt_pkg::MODE_REST;
              wo      = emit(wo, c);
            end
          end else if (c == clt_pkg::CH_SLASH) begin
            wo.held = 1'b1;
          end else begin
            wo = emit(wo, c);
          end
        end
        clt_pkg::MODE_REST_WS: begin
          if (!is_space(c)) begin
            wo.mode = clt_pkg::MODE_REST;
            wo      = emit(wo, c);
          end
        end
        clt_pkg::MODE_REST: begin
          wo = emit(wo, c);
        end
        default: begin
          wo.mode = wi.mode;
        end
      endcase
    end
    return wo;
  endfunction

  // The byte after a held slash decides whether the slash opened a comment.
  function automatic work_t resolve(work_t wi, logic [7:0] c);
    work_t wo;
    wo      = wi;
    wo.held = 1'b0;
    if (wo.mode == clt_pkg::MODE_SKIP) begin
      if (c == clt_pkg::CH_SLASH) begin
        wo.mode = clt_pkg::MODE_IGNORE;
      end else if (c == clt_pkg::CH_STAR) begin
        wo.mode = clt_pkg::MODE_COMMENT;
        wo.star = 1'b1;
      end else begin
        wo      = start_token(wo);
        wo      = emit(wo, clt_pkg::CH_SLASH);
        wo.mode = clt_pkg::MODE_BARE;
        wo      = plain(wo, c);
      end
    end else if (c == clt_pkg::CH_SLASH || c == clt_pkg::CH_STAR) begin
      // A comment opener ends a bare token; the slash is then replayed.
      wo = emit(wo, clt_pkg::CH_NUL);
      wo = enter_skip(wo);
      wo = plain(wo, clt_pkg::CH_SLASH);
      if (wo.held) begin
        wo.held = 1'b0;
        if (c == clt_pkg::CH_SLASH) begin
          wo.mode = clt_pkg::MODE_IGNORE;
        end else begin
          wo.mode = clt_pkg::MODE_COMMENT;
          wo.star = 1'b1;
        end
      end else begin
        wo = plain(wo, c);
      end
    end else begin
      wo = emit(wo, clt_pkg::CH_SLASH);
      wo = plain(wo, c);
    end
    return wo;
  endfunction

  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    w      = '0;
    w.mode = mode;
    w.held = held;
    w.star = star;
    w.sp   = sp;
    w.tok  = tok;
    w.lim  = lim;
    w.base = pos;
    if (mode == clt_pkg::MODE_LINE) begin
      w.lim  = (token_limit > clt_pkg::LIMIT_CAP) ? clt_pkg::LIMIT_CAP : token_limit;
      w.tok  = 10'd0;
      w.held = 1'b0;
      w.star = 1'b0;
      w.sp   = 1'b0;
      w      = enter_skip(w);
    end
    if (w.held) begin
      w = resolve(w, char_in);
    end else begin
      w = plain(w, char_in);
    end
    pos_sum  = {1'b0, pos} + {11'd0, w.ne};
    pos_next = (pos_sum >= {1'b0, clt_pkg::POOL_LAST}) ? clt_pkg::POOL_LAST : pos_sum[12:0];
  end

  assign q_push      = accept && (w.n != 3'd0);
  assign q_data.last = w.n[1:0] - 2'd1;
  assign q_data.slot = w.slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= clt_pkg::MODE_LINE;
      held <= 1'b0;
      star <= 1'b0;
      sp   <= 1'b0;
      tok  <= 10'd0;
      lim  <= 10'd0;
      pos  <= 13'd0;
    end else if (accept) begin
      mode <= w.mode;
      held <= w.held;
      star <= w.star;
      sp   <= w.sp;
      tok  <= w.tok;
      lim  <= w.lim;
      pos  <= pos_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clt_queue.sv
// Short queue of result bundles between the front end and the back end.
// Depends on clt_pkg.
`default_nettype none

module clt_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire clt_pkg::bundle_t  push_data,
  output logic                   full,
  input  wire logic              pop,
  output clt_pkg::bundle_t       head,
  output logic                   empty
);

  clt_pkg::bundle_t store [clt_pkg::QUEUE_DEPTH];

  logic [clt_pkg::QPTR_W-1:0] wr_ptr;
  logic [clt_pkg::QPTR_W-1:0] rd_ptr;
  logic [clt_pkg::QPTR_W:0]   count;
  logic                       do_push;
  logic                       do_pop;

  assign full    = (count == (clt_pkg::QPTR_W + 1)'(clt_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clt_back.sv
// Back end: takes bundles from the queue and hands out one result per cycle,
// unless result_stall holds it, through a registered output. Depends on clt_pkg.
`default_nettype none

module clt_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire clt_pkg::bundle_t  head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic                   kind,
  output logic [12:0]            pool_address,
  output logic [7:0]             pool_byte,
  output logic                   token_start,
  output logic [8:0]             token_index,
  output logic [9:0]             token_count,
  output logic                   run_end
);

  logic [1:0]       sel;
  logic             load;
  logic             at_last;
  clt_pkg::result_t cur;

  assign load    = !result_valid || !result_stall;
  assign cur     = head.slot[sel];
  assign at_last = (sel == head.last);
  assign pop     = load && !empty && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sel          <= 2'd0;
    end else if (load) begin
      result_valid <= !empty;
      if (!empty) begin
        sel <= at_last ? 2'd0 : sel + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      kind         <= cur.kind;
      pool_address <= cur.pool_address;
      pool_byte    <= cur.pool_byte;
      token_start  <= cur.token_start;
      token_index  <= cur.token_index;
      token_count  <= cur.token_count;
      run_end      <= at_last;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/command_line_tokenizer_core.sv
// Command line tokenizer, top level: front end, bundle queue, back end.
// The first result of a byte is written to the queue store and then to the registered output
// port. Throughput: one byte per cycle while the queue is not full; the output port gives one
// result per cycle unless result_stall holds it, so a byte causing n results holds the back end
// until all n are out, and the four-bundle queue stalls input only when four bundles are waiting.
// Reset: synchronous; parser returns to line start, queue and output empty.
`default_nettype none

module command_line_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  char_in,
  input  wire logic [9:0]  token_limit,
  input  wire logic        item_valid,
  output logic             item_stall,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             kind,
  output logic [12:0]      pool_address,
  output logic [7:0]       pool_byte,
  output logic             token_start,
  output logic [8:0]       token_index,
  output logic [9:0]       token_count,
  output logic             run_end
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  clt_pkg::bundle_t q_data;
  clt_pkg::bundle_t q_head;

  clt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .char_in     (char_in),
    .token_limit (token_limit),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  clt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  clt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .empty        (q_empty),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .pool_address (pool_address),
    .pool_byte    (pool_byte),
    .token_start  (token_start),
    .token_index  (token_index),
    .token_count  (token_count),
    .run_end      (run_end)
  );

  // A bundle is never offered to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("bundle pushed into full queue");

  // The line summary is always the final result of its byte.
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == clt_pkg::KIND_SUMMARY) |-> run_end)
    else $error("summary not marked as last result");

  // Only pool writes carry a token start mark.
  a_start_on_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && token_start |-> (kind == clt_pkg::KIND_WRITE))
    else $error("token start on summary");

  // The output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

FILE: verif/command_line_tokenizer_core_tb.sv
// Self-checking testbench for command_line_tokenizer_core: random command lines in.
// Depends on clt_pkg for the parser modes, the result kinds, the character codes and the sizes.
// A byte-level tokenizer model in this file predicts every pool write and line summary.
module command_line_tokenizer_core_tb;

  typedef struct packed {
    logic        kind;
    logic [12:0] addr;
    logic [7:0]  pbyte;
    logic        start;
    logic [8:0]  idx;
    logic [9:0]  count;
    logic        last;
  } pool_op_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [9:0] lim;
    logic       hold;
  } line_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  char_in = '0;
  logic [9:0]  token_limit = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        kind;
  logic [12:0] pool_address;
  logic [7:0]  pool_byte;
  logic        token_start;
  logic [8:0]  token_index;
  logic [9:0]  token_count;
  logic        run_end;

  command_line_tokenizer_core dut (
    .clk(clk), .rst(rst), .char_in(char_in), .token_limit(token_limit),
    .item_valid(item_valid), .item_stall(item_stall),
    .result_valid(result_valid), .result_stall(result_stall),
    .kind(kind), .pool_address(pool_address), .pool_byte(pool_byte),
    .token_start(token_start), .token_index(token_index),
    .token_count(token_count), .run_end(run_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Tokenizer state as the block should hold it.
  logic [2:0] tk_mode = clt_pkg::MODE_LINE;
  bit         tk_slash = 1'b0;
  bit         tk_star = 1'b0;
  bit         tk_fresh = 1'b0;
  int         tk_count = 0;
  int         tk_pos = 0;
  int         tk_limit = 0;

  pool_op_t   step_ops[$];
  logic [7:0] char_stack[$];
  pool_op_t   pool_ops_due[$];
  line_req_t  line_bytes[$];
  logic [7:0] line_buf[$];

  bit         failed = 1'b0;
  int         send_gap = 0;
  int         send_calm = 0;
  int         stall_left = 0;
  int         stall_calm = 0;
  line_req_t  next_req;
  pool_op_t   due_op;

  function automatic bit is_blank(logic [7:0] c);
    if (c == clt_pkg::CH_DC4 || c == clt_pkg::CH_NAK || c == clt_pkg::CH_SYN ||
        c == clt_pkg::CH_NUL) return 1'b0;
    return (c <= clt_pkg::CH_SPACE);
  endfunction

  function automatic void put_op(bit k, int addr, logic [7:0] b, bit st, int idx, int cnt);
    pool_op_t op;
    if (step_ops.size() >= clt_pkg::SLOTS) return;
    op.kind  = k;
    op.addr  = 13'(addr);
    op.pbyte = b;
    op.start = st;
    op.idx   = 9'(idx);
    op.count = 10'(cnt);
    op.last  = 1'b0;
    step_ops.push_back(op);
  endfunction

  function automatic void store_byte(logic [7:0] b);
    put_op(clt_pkg::KIND_WRITE, tk_pos, b, tk_fresh, (tk_count > 0) ? tk_count - 1 : 0, 0);
    tk_fresh = 1'b0;
    tk_pos = (tk_pos + 1 >= clt_pkg::POOL_BYTES - 2) ? clt_pkg::POOL_BYTES - 2 : tk_pos + 1;
  endfunction

  function automatic void begin_token();
    tk_count++;
    tk_fresh = 1'b1;
  endfunction

  // After a token closes: either skip to the next one, start the raw tail token, or stop.
  function automatic void after_token();
    tk_mode = clt_pkg::MODE_SKIP;
    if (tk_count >= tk_limit) begin
      tk_mode = clt_pkg::MODE_IGNORE;
    end else if (tk_limit > 0 && tk_count == tk_limit - 1) begin
      begin_token();
      tk_mode = clt_pkg::MODE_REST_WS;
    end
  endfunction

  // Characters that must be re-fed go to the front of char_stack, so they are
  // handled in order before anything that was pending.
  function automatic void step_char(logic [7:0] c);
    if (tk_slash) begin
      tk_slash = 1'b0;
      if (tk_mode == clt_pkg::MODE_SKIP) begin
        if (c == clt_pkg::CH_SLASH) begin
          tk_mode = clt_pkg::MODE_IGNORE;
        end else if (c == clt_pkg::CH_STAR) begin
          tk_mode = clt_pkg::MODE_COMMENT;
          tk_star = 1'b1;
        end else begin
          begin_token();
          store_byte(clt_pkg::CH_SLASH);
          tk_mode = clt_pkg::MODE_BARE;
          char_stack.push_front(c);
        end
      end else if (c == clt_pkg::CH_SLASH || c == clt_pkg::CH_STAR) begin
        store_byte(clt_pkg::CH_NUL);
        after_token();
        char_stack.push_front(c);
        char_stack.push_front(clt_pkg::CH_SLASH);
      end else begin
        store_byte(clt_pkg::CH_SLASH);
        char_stack.push_front(c);
      end
      return;
    end
    if (c == clt_pkg::CH_NUL) begin
      if (tk_mode == clt_pkg::MODE_BARE || tk_mode == clt_pkg::MODE_QUOTED ||
          tk_mode == clt_pkg::MODE_REST_WS || tk_mode == clt_pkg::MODE_REST)
        store_byte(clt_pkg::CH_NUL);
      put_op(clt_pkg::KIND_SUMMARY, 0, clt_pkg::CH_NUL, 1'b0, 0, tk_count);
      tk_mode = clt_pkg::MODE_LINE;
      tk_star = 1'b0;
      tk_fresh = 1'b0;
      return;
    end
    case (tk_mode)
      clt_pkg::MODE_SKIP: begin
        if (c == clt_pkg::CH_SLASH) begin
          tk_slash = 1'b1;
        end else if (c == clt_pkg::CH_QUOTE) begin
          begin_token();
          tk_mode = clt_pkg::MODE_QUOTED;
        end else if (!is_blank(c)) begin
          begin_token();
          store_byte(c);
          tk_mode = clt_pkg::MODE_BARE;
        end
      end
      clt_pkg::MODE_COMMENT: begin
        if (c == clt_pkg::CH_SLASH && tk_star) begin
          tk_star = 1'b0;
          after_token();
        end else begin
          tk_star = (c == clt_pkg::CH_STAR);
        end
      end
      clt_pkg::MODE_QUOTED: begin
        if (c == clt_pkg::CH_QUOTE) begin
          store_byte(clt_pkg::CH_NUL);
          after_token();
        end else begin
          store_byte(c);
        end
      end
      clt_pkg::MODE_BARE: begin
        if (is_blank(c)) begin
          store_byte(clt_pkg::CH_NUL);
          after_token();
        end else if (c == clt_pkg::CH_QUOTE) begin
          store_byte(clt_pkg::CH_NUL);
          after_token();
          char_stack.push_front(c);
        end else if (c == clt_pkg::CH_SLASH) begin
          tk_slash = 1'b1;
        end else begin
          store_byte(c);
        end
      end
      clt_pkg::MODE_REST_WS: begin
        if (!is_blank(c)) begin
          tk_mode = clt_pkg::MODE_REST;
          store_byte(c);
        end
      end
      clt_pkg::MODE_REST: store_byte(c);
      default: ;
    endcase
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic [9:0] lim);
    logic [7:0] ch;
    pool_op_t   op;
    step_ops.delete();
    if (tk_mode == clt_pkg::MODE_LINE) begin
      tk_limit = (lim > clt_pkg::LIMIT_CAP) ? clt_pkg::TOKEN_LIMIT_MAX : int'(lim);
      tk_count = 0;
      tk_slash = 1'b0;
      tk_star = 1'b0;
      tk_fresh = 1'b0;
      after_token();
    end
    char_stack.push_back(c);
    while (char_stack.size() > 0) begin
      ch = char_stack.pop_front();
      step_char(ch);
    end
    if (step_ops.size() > 0) begin
      op = step_ops.pop_back();
      op.last = 1'b1;
      step_ops.push_back(op);
    end
    foreach (step_ops[i]) pool_ops_due.push_back(step_ops[i]);
  endfunction

  // Idle length for either side: mostly none, some short, a few long, and
  // now and then a calm stretch with no idling at all.
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Line construction.
  function automatic void put_ch(logic [7:0] c);
    line_buf.push_back(c);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_blank(c) || c == clt_pkg::CH_QUOTE || c == clt_pkg::CH_SLASH);
    return c;
  endfunction

  function automatic void put_blank();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0, 1: put_ch(clt_pkg::CH_SPACE);
        2: put_ch(8'($urandom_range(1, 19)));
        default: put_ch(8'($urandom_range(23, 32)));
      endcase
    end
  endfunction

  function automatic void put_word();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) put_ch(word_char());
    if ($urandom_range(0, 6) == 0) begin
      put_ch(clt_pkg::CH_SLASH);
      put_ch(word_char());
    end
  endfunction

  function automatic void put_quoted();
    int n;
    logic [7:0] c;
    put_ch(clt_pkg::CH_QUOTE);
    n = $urandom_range(0, 5);
    repeat (n) begin
      c = 8'($urandom_range(1, 255));
      put_ch((c == clt_pkg::CH_QUOTE) ? clt_pkg::CH_SLASH : c);
    end
    if ($urandom_range(0, 9) != 0) put_ch(clt_pkg::CH_QUOTE);
  endfunction

  function automatic void put_comment();
    int n;
    put_ch(clt_pkg::CH_SLASH);
    put_ch(clt_pkg::CH_STAR);
    if ($urandom_range(0, 4) == 0) begin
      put_ch(clt_pkg::CH_SLASH);
    end else begin
      n = $urandom_range(0, 4);
      repeat (n) put_ch(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 9) != 0) begin
        put_ch(clt_pkg::CH_STAR);
        put_ch(clt_pkg::CH_SLASH);
      end
    end
  endfunction

  function automatic void put_line_comment();
    int n;
    put_ch(clt_pkg::CH_SLASH);
    put_ch(clt_pkg::CH_SLASH);
    n = $urandom_range(0, 4);
    repeat (n) put_ch(8'($urandom_range(1, 255)));
  endfunction

  // The limit rides on the first byte; the other bytes carry random limits,
  // which the block must ignore.
  function automatic void flush_line(int limit, bit hold);
    line_req_t req;
    line_buf.push_back(clt_pkg::CH_NUL);
    foreach (line_buf[i]) begin
      req.ch   = line_buf[i];
      req.lim  = (i == 0) ? 10'(limit) : 10'($urandom_range(0, 1023));
      req.hold = hold && (i == 0);
      line_bytes.push_back(req);
    end
    line_buf.delete();
  endfunction

  function automatic int pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 15) return 1;
    if (r < 75) return $urandom_range(2, 6);
    if (r < 85) return $urandom_range(7, clt_pkg::TOKEN_LIMIT_MAX);
    if (r < 92) return clt_pkg::TOKEN_LIMIT_MAX;
    return $urandom_range(clt_pkg::TOKEN_LIMIT_MAX + 1, 1023);
  endfunction

  function automatic void build_random_line();
    int pieces;
    int r;
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(0, 12);
      repeat (n) put_ch(8'($urandom_range(1, 255)));
      return;
    end
    if ($urandom_range(0, 1) == 0) put_blank();
    pieces = $urandom_range(0, 6);
    repeat (pieces) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        put_word();
      end else if (r < 58) begin
        put_quoted();
      end else if (r < 70) begin
        put_blank();
      end else if (r < 82) begin
        put_comment();
      end else if (r < 88) begin
        put_line_comment();
      end else if (r < 94) begin
        put_word();
        put_comment();
      end else begin
        put_word();
        put_quoted();
      end
      if ($urandom_range(0, 2) != 0) put_blank();
    end
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) tokenize_byte(char_in, token_limit);
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (line_bytes.size() == 0) begin
          item_valid <= 1'b0;
        end else begin
          next_req = line_bytes[0];
          if (next_req.hold && pool_ops_due.size() != 0) begin
            item_valid <= 1'b0;
          end else begin
            void'(line_bytes.pop_front());
            char_in     <= next_req.ch;
            token_limit <= next_req.lim;
            item_valid  <= 1'b1;
            send_gap = pick_idle(send_calm);
          end
        end
      end
    end
  end

  // Result monitor and output stall.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pool_ops_due.size() == 0) begin
          $error("unexpected result: kind %0d address %0d byte %0d",
                 kind, pool_address, pool_byte);
          failed = 1'b1;
        end else begin
          due_op = pool_ops_due.pop_front();
          check_field("kind", due_op.kind, kind);
          check_field("pool_address", due_op.addr, pool_address);
          check_field("pool_byte", due_op.pbyte, pool_byte);
          check_field("token_start", due_op.start, token_start);
          check_field("token_index", due_op.idx, token_index);
          check_field("token_count", due_op.count, token_count);
          check_field("run_end", due_op.last, run_end);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        stall_left = pick_idle(stall_calm);
        if (stall_left > 0) begin
          stall_left--;
          result_stall <= 1'b1;
        end else begin
          result_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    int random_bytes;
    int n;
    bit paused;
    random_bytes = 0;
    paused = 1'b0;

    // Limit above the cap, zero limit, raw tail token left empty.
    put_text("a b");
    flush_line(1023, 1'b0);
    put_text("x\"y");
    flush_line(0, 1'b0);
    put_text("ab ");
    flush_line(2, 1'b0);
    // The opening star also closes the comment.
    put_text("/*/x");
    flush_line(4, 1'b0);
    put_ch(8'hFF);
    put_ch(clt_pkg::CH_DC4);
    put_ch(8'h7F);
    put_ch(clt_pkg::CH_SPACE);
    put_ch(8'h80);
    put_ch(8'h01);
    flush_line(clt_pkg::TOKEN_LIMIT_MAX, 1'b0);
    // A bare token cut short by a line comment.
    put_text("a//");
    flush_line(5, 1'b0);

    // The first random line and one in the middle wait for a drained output.
    while (random_bytes < 330) begin
      build_random_line();
      n = line_buf.size() + 1;
      flush_line(pick_limit(), (random_bytes == 0) || (!paused && random_bytes >= 165));
      if (random_bytes >= 165) paused = 1'b1;
      random_bytes += n;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (line_bytes.size() > 0 || item_valid) @(posedge clk);
    while (pool_ops_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("** command_line_tokenizer_core: PASSED **");
    end else begin
      $display("** command_line_tokenizer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    repeat (5_000_000) @(posedge clk);
    $display("** command_line_tokenizer_core: FAILED **");
    $finish;
  end

endmodule
